>>> hdl/fla_pkg.sv
// Package for the FIFO hand-off lock: request and result transfer types,
// command and status codes, and the per-cell control word.
// Depends on nothing; every other file in hdl/ refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package fla_pkg;

    localparam int IdFieldW    = 8;
    localparam int StatusW     = 3;
    localparam int WaitCountW  = 5;

    typedef enum logic {
        CMD_LOCK   = 1'b0,
        CMD_UNLOCK = 1'b1
    } cmd_e;

    typedef enum logic [StatusW-1:0] {
        ST_GRANTED    = 3'd0,
        ST_QUEUED     = 3'd1,
        ST_FULL       = 3'd2,
        ST_RELEASED   = 3'd3,
        ST_HANDOVER   = 3'd4,
        ST_NOT_OWNER  = 3'd5,
        ST_NOT_LOCKED = 3'd6
    } status_e;

    typedef struct packed {
        logic                cmd;
        logic [IdFieldW-1:0] requester_id;
    } req_t;

    typedef struct packed {
        logic [StatusW-1:0]    status;
        logic [IdFieldW-1:0]   woken_id;
        logic [WaitCountW-1:0] waiting_count;
    } result_t;

    // Operation applied to the waiter queue in one cycle.
    typedef struct packed {
        logic push;
        logic pop;
    } queue_op_t;

    // Control word of one queue cell.
    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctl_t;

endpackage

`default_nettype wire

>>> hdl/fifo_handoff_lock.sv
// Top level of the FIFO hand-off lock: owner and lock flag, request decode,
// and the registered result. Depends on fla_pkg, fla_id_narrow and fla_queue.
//
//   Channel   Handshake          Payload              Direction
//   request   start / busy       req    (req_t)       in
//   result    done (strobe)      result (result_t)    out
//
// Cycles: a request accepted at one edge (start high, busy low) has its
//   result on the result ports for exactly the following cycle, marked by
//   done. No request holds the block, so busy stays low and
//   a new request may be accepted at every edge: one request per cycle.
// Reset: rst_n clears the lock flag, the owner, the waiter count and done.
//   The waiter cells themselves are not cleared; a cell is read only after
//   a waiter was written into it.
// Stalls: the receiver cannot stall; each result is taken when shown.
`timescale 1ns / 1ps
`default_nettype none

module fifo_handoff_lock #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_WIDTH    = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire fla_pkg::req_t req,
    output logic               done,
    output fla_pkg::result_t   result
);

    // Ids are carried in an 8-bit field, so at most eight bits can matter.
    localparam int ID_W = (ID_WIDTH < fla_pkg::IdFieldW) ? ID_WIDTH : fla_pkg::IdFieldW;
    // The waiter count must hold QUEUE_DEPTH itself.
    localparam int CW   = $clog2(QUEUE_DEPTH + 1);

    logic                locked_reg;
    logic                locked_next;
    logic [ID_W-1:0]     owner_reg;
    logic [ID_W-1:0]     owner_next;
    logic                done_reg;
    fla_pkg::result_t    result_reg;
    fla_pkg::result_t    result_next;

    logic                accept;
    logic [ID_W-1:0]     req_id;
    logic [ID_W-1:0]     head_id;
    logic [CW-1:0]       q_count;
    logic [CW-1:0]       count_after;
    logic [CW+4:0]       count_wide;
    logic                q_full;
    logic                q_empty;
    fla_pkg::queue_op_t  q_op;
    fla_pkg::status_e    status;
    logic [ID_W-1:0]     woken;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    fla_id_narrow #(
        .ID_W (ID_W)
    ) u_narrow (
        .full_id (req.requester_id),
        .id      (req_id)
    );

    fla_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_W        (ID_W),
        .CW          (CW)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .op      (q_op),
        .push_id (req_id),
        .head_id (head_id),
        .count   (q_count)
    );

    assign q_full  = (q_count == CW'(QUEUE_DEPTH));
    assign q_empty = (q_count == '0);

    // Request decode. An unlock checks ownership before the lock flag, so
    // the last owner of a free lock is told the lock is not held, while any
    // other id is told it is not the owner. Errors and a full queue leave
    // all state as it was.
    always_comb
    begin
        locked_next = locked_reg;
        owner_next  = owner_reg;
        q_op        = '0;
        woken       = '0;
        status      = fla_pkg::ST_FULL;

        if (req.cmd == fla_pkg::CMD_LOCK)
        begin
            if (!locked_reg)
            begin
                locked_next = 1'b1;
                owner_next  = req_id;
                status      = fla_pkg::ST_GRANTED;
            end
            else if (!q_full)
            begin
                q_op.push = 1'b1;
                status    = fla_pkg::ST_QUEUED;
            end
            else
            begin
                status = fla_pkg::ST_FULL;
            end
        end
        else
        begin
            if (req_id != owner_reg)
            begin
                status = fla_pkg::ST_NOT_OWNER;
            end
            else if (!locked_reg)
            begin
                status = fla_pkg::ST_NOT_LOCKED;
            end
            else if (q_empty)
            begin
                locked_next = 1'b0;
                status      = fla_pkg::ST_RELEASED;
            end
            else
            begin
                // Ownership passes straight to the oldest waiter.
                q_op.pop   = 1'b1;
                owner_next = head_id;
                woken      = head_id;
                status     = fla_pkg::ST_HANDOVER;
            end
        end

        if (!accept)
        begin
            locked_next = locked_reg;
            owner_next  = owner_reg;
            q_op        = '0;
        end
    end

    // Waiter count after this request, shown in the 5-bit result field.
    always_comb
    begin
        count_after = q_count;
        if (q_op.push)
        begin
            count_after = q_count + CW'(1);
        end
        else if (q_op.pop)
        begin
            count_after = q_count - CW'(1);
        end
    end

    assign count_wide = (CW + 5)'(count_after);

    always_comb
    begin
        result_next.status        = status;
        result_next.woken_id      = fla_pkg::IdFieldW'(woken);
        result_next.waiting_count = count_wide[fla_pkg::WaitCountW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            locked_reg <= 1'b0;
            owner_reg  <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            locked_reg <= locked_next;
            owner_reg  <= owner_next;
            done_reg   <= accept;
        end
    end

    // The result payload needs no reset; done qualifies it.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Every accepted request produces exactly one result in the next cycle.
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("request transfer without a result transfer");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> !done)
        else $error("result transfer without a request transfer");

    // A hand-over keeps the lock held; a release leaves it free with no waiters.
    a_handover_locked: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.status == fla_pkg::ST_HANDOVER) |-> locked_reg)
        else $error("lock free after hand-over");

    a_release_free: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.status == fla_pkg::ST_RELEASED) |-> !locked_reg && q_empty)
        else $error("lock held or waiters left after release");

    // The waiter count never passes the queue depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= CW'(QUEUE_DEPTH))
        else $error("waiter count beyond queue depth");

endmodule

`default_nettype wire

>>> hdl/fla_cell.sv
// One cell of the waiter queue: holds one waiting id.
// Depends on fla_pkg for the cell control word.
`timescale 1ns / 1ps
`default_nettype none

module fla_cell #(
    parameter int ID_W = 8
) (
    input  wire logic              clk,
    input  wire fla_pkg::cell_ctl_t ctl,
    input  wire logic [ID_W-1:0]   new_id,
    input  wire logic [ID_W-1:0]   nbr_id,
    output logic      [ID_W-1:0]   id
);

    logic [ID_W-1:0] id_reg;
    logic [ID_W-1:0] id_next;

    // A load writes the id being queued; a shift takes the neighbor's id
    // one step closer to the head.
    always_comb
    begin
        id_next = id_reg;
        if (ctl.load)
        begin
            id_next = new_id;
        end
        else if (ctl.shift)
        begin
            id_next = nbr_id;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

    assign id = id_reg;

endmodule

`default_nettype wire

>>> hdl/fla_queue.sv
// Waiter queue built as a row of fla_cell instances with a fill count.
// The head is always cell 0; a pop shifts every cell one place toward it.
// Depends on fla_pkg and fla_cell.
`timescale 1ns / 1ps
`default_nettype none

module fla_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_W        = 8,
    parameter int CW          = 5
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire fla_pkg::queue_op_t op,
    input  wire logic [ID_W-1:0]   push_id,
    output logic      [ID_W-1:0]   head_id,
    output logic      [CW-1:0]     count
);

    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic [ID_W-1:0] cell_id [QUEUE_DEPTH];

    always_comb
    begin
        count_next = count_reg;
        if (op.push)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (op.pop)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            fla_pkg::cell_ctl_t ctl;
            logic [ID_W-1:0]    nbr;

            // The new waiter lands in the first free cell.
            assign ctl = '{load: op.push && (count_reg == CW'(gi)), shift: op.pop};

            if (gi == QUEUE_DEPTH - 1)
            begin : g_last
                assign nbr = '0;
            end
            else
            begin : g_mid
                assign nbr = cell_id[gi+1];
            end

            fla_cell #(
                .ID_W (ID_W)
            ) u_cell (
                .clk    (clk),
                .ctl    (ctl),
                .new_id (push_id),
                .nbr_id (nbr),
                .id     (cell_id[gi])
            );
        end
    endgenerate

    assign head_id = cell_id[0];
    assign count   = count_reg;

endmodule

`default_nettype wire

>>> hdl/fla_top_notes.sv
// Id narrowing helper: keeps the low ID_W bits of a requester id.
// Used by the top level ahead of the owner compare and the waiter queue.
// Depends on fla_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fla_id_narrow #(
    parameter int ID_W = 8
) (
    input  wire logic [fla_pkg::IdFieldW-1:0] full_id,
    output logic      [ID_W-1:0]              id
);

    // Only the low ID_W bits of a requester id take part in the lock.
    assign id = full_id[ID_W-1:0];

endmodule

`default_nettype wire

>>> verif/tb.sv
// Self-checking testbench for fifo_handoff_lock: directed lock, unlock, queue-full and
// hand-off cases, followed by biased random request traffic with sender gaps.
// Depends on fla_pkg and fifo_handoff_lock from hdl/.
`timescale 1ns / 1ps

module tb;
    import fla_pkg::*;

    localparam int QDepth      = 16;
    localparam int TimeoutNs   = 1_000_000;
    localparam int SettleLimit = 200;
    localparam int DrainCycles = 4;
    localparam int RandomItems = 2000;
    localparam int PendDepth   = 8;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    req_t    req;
    logic    done;
    result_t result;

    // Shadow copy of the mutex, advanced once per accepted request.
    logic              mtx_locked;
    logic [IdFieldW-1:0] mtx_owner;
    logic [IdFieldW-1:0] waiter_ids [QDepth];
    int unsigned       waiter_head;
    int unsigned       waiter_tail;
    int unsigned       waiter_count;

    // Outcomes predicted at request acceptance, oldest first, kept in a ring.
    result_t     pending_outcomes [PendDepth];
    int unsigned pend_wr;
    int unsigned pend_rd;
    int unsigned error_count;
    int unsigned burst_left;

    fifo_handoff_lock #(
        .QUEUE_DEPTH(QDepth),
        .ID_WIDTH   (IdFieldW)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .result(result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop in case a handshake never completes.
    initial
    begin
        #(TimeoutNs);
        $display("ERROR: timeout, run did not complete");
        $display("FAIL");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR: %0t ns: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic int unsigned pending_size();
        return pend_wr - pend_rd;
    endfunction

    task automatic store_outcome(input result_t o);
        if (pending_size() >= PendDepth)
        begin
            report_mismatch("too many outstanding results");
            return;
        end
        pending_outcomes[pend_wr % PendDepth] = o;
        pend_wr++;
    endtask

    function automatic result_t take_outcome();
        result_t o;
        o = pending_outcomes[pend_rd % PendDepth];
        pend_rd++;
        return o;
    endfunction

    // Applies one request to the shadow mutex and returns the outcome it must produce.
    function automatic result_t predict_lock_outcome(input req_t r);
        result_t o;
        o = '0;
        if (r.cmd == CMD_LOCK)
        begin
            if (!mtx_locked)
            begin
                mtx_locked = 1'b1;
                mtx_owner  = r.requester_id;
                o.status   = ST_GRANTED;
            end
            else if (waiter_count < QDepth)
            begin
                waiter_ids[waiter_tail] = r.requester_id;
                waiter_tail  = (waiter_tail + 1) % QDepth;
                waiter_count++;
                o.status = ST_QUEUED;
            end
            else
            begin
                o.status = ST_FULL;
            end
        end
        else
        begin
            // The owner compare comes first, so a free mutex still answers
            // not-locked to its last owner and not-owner to everyone else.
            if (r.requester_id != mtx_owner)
            begin
                o.status = ST_NOT_OWNER;
            end
            else if (!mtx_locked)
            begin
                o.status = ST_NOT_LOCKED;
            end
            else if (waiter_count == 0)
            begin
                mtx_locked = 1'b0;
                o.status   = ST_RELEASED;
            end
            else
            begin
                mtx_owner   = waiter_ids[waiter_head];
                waiter_head = (waiter_head + 1) % QDepth;
                waiter_count--;
                o.woken_id = mtx_owner;
                o.status   = ST_HANDOVER;
            end
        end
        o.waiting_count = waiter_count[WaitCountW-1:0];
        return o;
    endfunction

    // Presents one request from the falling edge on and holds it until the
    // block takes the transfer; start stays high into the next request.
    task automatic send_request(input cmd_e op, input logic [IdFieldW-1:0] id);
        req_t item;
        item.cmd          = op;
        item.requester_id = id;
        @(negedge clk);
        start <= 1'b1;
        req   <= item;
        do @(posedge clk); while (busy !== 1'b0);
        store_outcome(predict_lock_outcome(item));
    endtask

    task automatic pause_sender(input int unsigned cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    // Sender works in bursts; between bursts it usually takes a short break.
    // Now and then a long burst runs back to back with no gaps at all.
    task automatic pace_sender();
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        if ($urandom_range(0, 4) != 0)
            pause_sender($urandom_range(1, 5));
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(0, 12);
    endtask

    task automatic send_paced(input cmd_e op, input logic [IdFieldW-1:0] id);
        send_request(op, id);
        pace_sender();
    endtask

    // Results come for exactly one cycle and cannot be held off, so every
    // strobe is checked at the edge that ends its cycle.
    task automatic check_outcome(input result_t got);
        result_t want;
        if (pending_size() == 0)
        begin
            report_mismatch($sformatf("result transfer with nothing expected: %h", got));
            return;
        end
        want = take_outcome();
        if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.woken_id !== want.woken_id)
            report_mismatch($sformatf("woken_id %h, expected %h", got.woken_id, want.woken_id));
        if (got.waiting_count !== want.waiting_count)
            report_mismatch($sformatf("waiting_count %0d, expected %0d",
                                      got.waiting_count, want.waiting_count));
    endtask

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
            check_outcome(result);
    end

    // Unlocks straight after reset: id 0 matches the cleared owner and sees a
    // free mutex, any other id is rejected as not the owner.
    task automatic test_unlock_after_reset();
        send_paced(CMD_UNLOCK, 8'h00);
        send_paced(CMD_UNLOCK, 8'h80);
    endtask

    // Grant, foreign unlock, release, then an unlock of the free mutex by the
    // owner it still remembers.
    task automatic test_grant_and_release();
        send_paced(CMD_LOCK,   8'hFF);
        send_paced(CMD_UNLOCK, 8'h7F);
        send_paced(CMD_UNLOCK, 8'hFF);
        send_paced(CMD_UNLOCK, 8'hFF);
    endtask

    // Fills the waiter queue, including a relock by the owner and a waiter with
    // id zero, and then overflows it once.
    task automatic test_queue_fill();
        send_paced(CMD_LOCK, 8'h55);
        send_paced(CMD_LOCK, 8'h55);
        send_paced(CMD_LOCK, 8'h00);
        send_paced(CMD_LOCK, 8'hAA);
        for (int i = 0; i < QDepth - 3; i++)
            send_paced(CMD_LOCK, 8'(i * 17 + 3));
        send_paced(CMD_LOCK, 8'h0F);
    endtask

    // Hands ownership down the queue: first back to the same id, then to id 0.
    task automatic test_handover();
        send_paced(CMD_UNLOCK, 8'h01);
        send_paced(CMD_UNLOCK, 8'h55);
        send_paced(CMD_UNLOCK, 8'h55);
        send_paced(CMD_UNLOCK, 8'h00);
    endtask

    // Random traffic in phases that lean toward filling, draining or neither,
    // so the queue swings between empty and full. Most unlocks come from the
    // real owner; the rest are random ids that mostly get rejected.
    task automatic test_random_traffic(input int unsigned n_items);
        int unsigned lock_pct;
        int unsigned pick;
        logic [IdFieldW-1:0] id;
        lock_pct = 50;
        for (int unsigned i = 0; i < n_items; i++)
        begin
            if (i % 64 == 0)
            begin
                pick     = $urandom_range(0, 2);
                lock_pct = (pick == 0) ? 85 : (pick == 1) ? 20 : 50;
            end
            if ($urandom_range(0, 99) < lock_pct)
            begin
                pick = $urandom_range(0, 7);
                case (pick)
                    0:       id = 8'h00;
                    1:       id = 8'hFF;
                    2:       id = mtx_owner;
                    default: id = 8'($urandom_range(0, 255));
                endcase
                send_paced(CMD_LOCK, id);
            end
            else
            begin
                if ($urandom_range(0, 99) < 80)
                    id = mtx_owner;
                else
                    id = 8'($urandom_range(0, 255));
                send_paced(CMD_UNLOCK, id);
            end
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        req          = '0;
        error_count  = 0;
        burst_left   = 0;
        pend_wr      = 0;
        pend_rd      = 0;
        mtx_locked   = 1'b0;
        mtx_owner    = '0;
        waiter_head  = 0;
        waiter_tail  = 0;
        waiter_count = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_unlock_after_reset();
        test_grant_and_release();
        test_queue_fill();
        test_handover();
        test_random_traffic(RandomItems);

        pause_sender(1);
        for (int i = 0; i < SettleLimit && pending_size() != 0; i++)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        if (pending_size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      pending_size()));

        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
